>>> rtl/olidf_pkg.sv
package olidf_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 5;
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_IDX_W + OUT_CNT_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_FIND   = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic [IDX_W-1:0]      idx;
        logic [ELEM_WIDTH-1:0] value;
    } cell_ctrl_t;

    function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[ELEM_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/olidf_cell.sv
module olidf_cell (
    input  logic                              aclk,
    input  olidf_pkg::cell_ctrl_t             ctrl,
    input  logic [olidf_pkg::IDX_W-1:0]       cell_idx,
    input  logic [olidf_pkg::ELEM_WIDTH-1:0]  left_data,
    input  logic [olidf_pkg::ELEM_WIDTH-1:0]  right_data,
    output logic [olidf_pkg::ELEM_WIDTH-1:0]  data,
    output logic                              match
);

    logic [olidf_pkg::ELEM_WIDTH-1:0] data_reg;
    logic [olidf_pkg::ELEM_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (cell_idx == ctrl.idx) begin
                data_next = ctrl.value;
            end else if (cell_idx > ctrl.idx) begin
                data_next = left_data;
            end
        end else if (ctrl.del) begin
            if (cell_idx >= ctrl.idx) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == ctrl.value);

endmodule

>>> rtl/ordered_list_insert_delete_find.sv
// A request accepted at one clock edge has its result registered and shown on m_tdata in the next cycle.
// Throughput: one request per cycle unless stalled; every cell of the list row shifts or compares
// its entry in the same cycle, and the first match is picked by one priority encoder.
// A new request enters in the cycle the held result is taken, so a stalled result stalls the input.
// Reset clears the entry count and the output valid; list entries are not cleared.
module ordered_list_insert_delete_find (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: value[31:0], position[36:32], zero fill.
    input  logic [olidf_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: req_type[1:0].
    input  logic [olidf_pkg::REQ_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: found_index[3:0], count[8:4], zero fill.
    output logic [olidf_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [olidf_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int D  = olidf_pkg::DEPTH;
    localparam int EW = olidf_pkg::ELEM_WIDTH;

    logic                                accept;
    logic [olidf_pkg::REQ_W-1:0]         kind;
    logic [olidf_pkg::POS_W-1:0]         pos;
    logic [olidf_pkg::CMP_W-1:0]         pos_w;
    logic [olidf_pkg::CMP_W-1:0]         cnt_w;
    logic                                ins_ok;
    logic                                del_ok;
    logic                                hit;
    logic [olidf_pkg::IDX_W-1:0]         hit_idx;
    olidf_pkg::cell_ctrl_t               ctrl;
    olidf_pkg::status_t                  status;
    logic [olidf_pkg::IDX_W-1:0]         res_idx;

    logic [olidf_pkg::CNT_W-1:0]         cnt_reg;
    logic [olidf_pkg::CNT_W-1:0]         cnt_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    olidf_pkg::status_t                  out_status_reg;
    logic [olidf_pkg::OUT_IDX_W-1:0]     out_idx_reg;
    logic [olidf_pkg::OUT_CNT_W-1:0]     out_cnt_reg;

    logic [EW-1:0]                       cell_data  [D];
    logic [EW-1:0]                       left_data  [D];
    logic [EW-1:0]                       right_data [D];
    logic [D-1:0]                        match;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = s_tuser;
    assign pos      = s_tdata[olidf_pkg::VALUE_W +: olidf_pkg::POS_W];
    assign pos_w    = olidf_pkg::CMP_W'(pos);
    assign cnt_w    = olidf_pkg::CMP_W'(cnt_reg);

    assign ins_ok = (kind == olidf_pkg::REQ_INSERT) && (cnt_w != olidf_pkg::CMP_W'(D))
                    && (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
    assign del_ok = (kind == olidf_pkg::REQ_DELETE) && (pos_w != '0) && (pos_w <= cnt_w);

    always_comb begin
        ctrl.ins   = accept && ins_ok;
        ctrl.del   = accept && del_ok;
        ctrl.idx   = olidf_pkg::IDX_W'(pos_w - 1'b1);
        ctrl.value = olidf_pkg::to_elem(s_tdata[olidf_pkg::VALUE_W-1:0]);
    end

    for (genvar k = 0; k < D; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign left_data[k] = '0;
        end else begin : g_left
            assign left_data[k] = cell_data[k-1];
        end
        if (k == D - 1) begin : g_last
            assign right_data[k] = '0;
        end else begin : g_right
            assign right_data[k] = cell_data[k+1];
        end
        olidf_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (olidf_pkg::IDX_W'(k)),
            .left_data  (left_data[k]),
            .right_data (right_data[k]),
            .data       (cell_data[k]),
            .match      (match[k])
        );
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = D - 1; k >= 0; k--) begin
            if (match[k] && (olidf_pkg::CMP_W'(k) < cnt_w)) begin
                hit     = 1'b1;
                hit_idx = olidf_pkg::IDX_W'(k);
            end
        end
    end

    always_comb begin
        status   = olidf_pkg::ST_OK;
        res_idx  = '0;
        cnt_next = cnt_reg;
        case (kind)
            olidf_pkg::REQ_INSERT: begin
                if (cnt_w == olidf_pkg::CMP_W'(D)) begin
                    status = olidf_pkg::ST_FULL;
                end else if (!ins_ok) begin
                    status = olidf_pkg::ST_BADPOS;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            olidf_pkg::REQ_DELETE: begin
                if (!del_ok) begin
                    status = olidf_pkg::ST_BADPOS;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            olidf_pkg::REQ_FIND: begin
                if (hit) begin
                    res_idx = hit_idx;
                end else begin
                    status = olidf_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                status = olidf_pkg::ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= status;
            out_idx_reg    <= olidf_pkg::OUT_IDX_W'(res_idx);
            out_cnt_reg    <= olidf_pkg::OUT_CNT_W'(cnt_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = olidf_pkg::M_TDATA_W'({out_cnt_reg, out_idx_reg});

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        olidf_pkg::CMP_W'(cnt_reg) <= olidf_pkg::CMP_W'(D))
        else $error("entry count exceeds list depth");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ins_ok) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("accepted insert did not grow the list by one");

    a_find_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == olidf_pkg::REQ_FIND) |=> (cnt_reg == $past(cnt_reg)))
        else $error("find changed the entry count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status == olidf_pkg::ST_FULL) |-> (cnt_w == olidf_pkg::CMP_W'(D)))
        else $error("full status reported on a list that is not full");

endmodule
